// ----- rtl/sao_pkg.sv -----
// Shared types, codes and object tables for the sensor advertisement parser.
// No dependencies; imported by sensor_advert_object_parser_unit.
package sao_pkg;

  // Kinds of result word
  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_MEASURE = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // Frame end status codes
  localparam logic [2:0] ST_COMPLETE  = 3'd0;
  localparam logic [2:0] ST_NOPAYLOAD = 3'd1;
  localparam logic [2:0] ST_UNKNOWN   = 3'd2;
  localparam logic [2:0] ST_TRUNC     = 3'd3;
  localparam logic [2:0] ST_ENCRYPTED = 3'd4;

  // Number of MAC bytes after the header
  localparam logic [2:0] MAC_BYTES = 3'd6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [7:0]  object_code;
    logic [31:0] raw_reading;
    logic [1:0]  scale_code;
    logic [2:0]  format_version;
    logic        encrypted_flag;
    logic        mac_present;
    logic        trigger_flag;
    logic [2:0]  end_status;
    logic        last_result;
  } out_word_t;

  // Data length of an object ID in bytes, zero when the ID is unknown
  function automatic logic [2:0] obj_len(input logic [7:0] id);
    logic [2:0] len;
    case (id) inside
      8'h01, 8'h2E, 8'h2F:
        len = 3'd1;
      8'h02, 8'h03, 8'h08, 8'h0C, 8'h12, 8'h13, 8'h14, 8'h3C, 8'h40, 8'h41,
      8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h51, 8'h52, 8'h56, 8'h57,
      8'h58, 8'h5E, 8'h5F:
        len = 3'd2;
      8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h49, 8'h4B:
        len = 3'd3;
      8'h3E, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h5B, 8'h5C:
        len = 3'd4;
      default:
        len = 3'd0;
    endcase
    return len;
  endfunction

  // Decimal scale: reading = raw * 10^-scale
  function automatic logic [1:0] obj_scale(input logic [7:0] id);
    logic [1:0] sc;
    case (id) inside
      8'h02, 8'h03, 8'h04, 8'h05, 8'h08, 8'h0B, 8'h14, 8'h44, 8'h5C, 8'h5E:
        sc = 2'd2;
      8'h0A, 8'h0C, 8'h42, 8'h43, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h51,
      8'h52:
        sc = 2'd3;
      8'h3F, 8'h45, 8'h46, 8'h47, 8'h4A:
        sc = 2'd1;
      default:
        sc = 2'd0;
    endcase
    return sc;
  endfunction

endpackage

// ----- rtl/sensor_advert_object_parser_unit.sv -----
// Each result word is registered into the result queue when its byte is accepted.
// Throughput: one byte per cycle while in_ready is high; a byte may yield two words, and
// in_ready drops while the four-word result queue has fewer than two free slots.
// Reset (rst, synchronous) returns the parser to waiting for a header and empties the queue.
// Depends on sao_pkg for word types, status codes and the object tables.
module sensor_advert_object_parser_unit
  import sao_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_MAC,
    PH_FIRST_ID,
    PH_ID,
    PH_DATA,
    PH_STOPPED,
    PH_ENC_WAIT,
    PH_ENC_SEEN
  } phase_t;

  phase_t      phase, phase_next;
  logic [2:0]  mac_left, mac_left_next;
  logic [7:0]  obj, obj_next;
  logic [2:0]  bytes_left, bytes_left_next;
  logic [31:0] acc, acc_next;
  logic [1:0]  pos, pos_next;
  logic        enc, enc_next;

  out_word_t   queue [4];
  logic [1:0]  wr_ptr, rd_ptr;
  logic [2:0]  count, count_next;

  logic [7:0]  b;
  logic        last;
  logic [2:0]  len;
  logic [31:0] shifted;
  logic        has_a;
  out_word_t   res_a, res_end, first_word;
  logic [2:0]  status;
  logic        in_fire, pop;
  logic [1:0]  npush;

  assign b       = in_data.data_byte;
  assign last    = in_data.frame_end;
  assign len     = obj_len(b);
  assign shifted = {24'd0, b} << {pos, 3'b000};

  assign in_ready  = (count <= 3'd2);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != 3'd0);
  assign out_data  = queue[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_comb begin
    phase_next      = phase;
    mac_left_next   = mac_left;
    obj_next        = obj;
    bytes_left_next = bytes_left;
    acc_next        = acc;
    pos_next        = pos;
    enc_next        = enc;
    has_a           = 1'b0;
    res_a           = '0;
    res_end         = '0;
    status          = ST_NOPAYLOAD;

    unique case (phase)
      PH_HEADER: begin
        has_a                = 1'b1;
        res_a.item_kind      = KIND_HEADER;
        res_a.format_version = b[7:5];
        res_a.encrypted_flag = b[0];
        res_a.mac_present    = b[1];
        res_a.trigger_flag   = b[2];
        enc_next             = b[0];
        if (b[1]) begin
          phase_next    = PH_MAC;
          mac_left_next = MAC_BYTES;
        end else begin
          phase_next = b[0] ? PH_ENC_WAIT : PH_FIRST_ID;
        end
      end
      PH_MAC: begin
        mac_left_next = mac_left - 3'd1;
        if (mac_left_next == 3'd0) begin
          phase_next = enc ? PH_ENC_WAIT : PH_FIRST_ID;
        end
      end
      PH_FIRST_ID, PH_ID: begin
        if (len == 3'd0) begin
          phase_next = PH_STOPPED;
        end else begin
          obj_next        = b;
          bytes_left_next = len;
          acc_next        = '0;
          pos_next        = 2'd0;
          phase_next      = PH_DATA;
        end
      end
      PH_DATA: begin
        // little-endian: each byte lands one octet higher
        acc_next        = acc | shifted;
        pos_next        = pos + 2'd1;
        bytes_left_next = bytes_left - 3'd1;
        if (bytes_left_next == 3'd0) begin
          has_a             = 1'b1;
          res_a.item_kind   = KIND_MEASURE;
          res_a.object_code = obj;
          res_a.raw_reading = acc_next;
          res_a.scale_code  = obj_scale(obj);
          phase_next        = PH_ID;
        end
      end
      PH_ENC_WAIT: begin
        phase_next = PH_ENC_SEEN;
      end
      default: begin
      end
    endcase

    unique case (phase_next)
      PH_ID:       status = ST_COMPLETE;
      PH_DATA:     status = ST_TRUNC;
      PH_STOPPED:  status = ST_UNKNOWN;
      PH_ENC_SEEN: status = ST_ENCRYPTED;
      default:     status = ST_NOPAYLOAD;
    endcase

    res_end.item_kind   = KIND_END;
    res_end.end_status  = status;
    res_end.last_result = 1'b1;
    res_a.last_result   = !last;

    // drop all frame context at the last byte
    if (last) begin
      phase_next      = PH_HEADER;
      mac_left_next   = 3'd0;
      obj_next        = 8'd0;
      bytes_left_next = 3'd0;
      acc_next        = '0;
      pos_next        = 2'd0;
      enc_next        = 1'b0;
    end

    first_word = has_a ? res_a : res_end;
    npush      = in_fire ? ({1'b0, has_a} + {1'b0, last}) : 2'd0;
    count_next = count + {1'b0, npush} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      mac_left   <= 3'd0;
      obj        <= 8'd0;
      bytes_left <= 3'd0;
      acc        <= '0;
      pos        <= 2'd0;
      enc        <= 1'b0;
      wr_ptr     <= 2'd0;
      rd_ptr     <= 2'd0;
      count      <= 3'd0;
    end else begin
      if (in_fire) begin
        phase      <= phase_next;
        mac_left   <= mac_left_next;
        obj        <= obj_next;
        bytes_left <= bytes_left_next;
        acc        <= acc_next;
        pos        <= pos_next;
        enc        <= enc_next;
      end
      if (npush != 2'd0) begin
        queue[wr_ptr] <= first_word;
      end
      if (npush == 2'd2) begin
        queue[wr_ptr + 2'd1] <= res_end;
      end
      wr_ptr <= wr_ptr + npush;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count_next;
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overflow");

  a_mac_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_MAC |-> (mac_left != 3'd0 && mac_left <= MAC_BYTES))
    else $error("MAC skip count out of range");

  a_data_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> (bytes_left != 3'd0 && bytes_left <= 3'd4))
    else $error("object byte count out of range");

  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && last |=> phase == PH_HEADER && count != 3'd0)
    else $error("frame end did not restart parsing or report");

  a_header_word: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == PH_HEADER |=> count != 3'd0)
    else $error("header byte produced no word");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for sensor_advert_object_parser_unit: drives service-data words
// with bursty valid and a stalling receiver, predicts every result word and compares them.
// Depends on sao_pkg for the word types, kind and status codes.
module tb_top;
  import sao_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1550;
  localparam int TAIL_CYCLES  = 20;

  typedef enum logic [2:0] {
    WAIT_HDR    = 3'd0,
    SKIP_MAC    = 3'd1,
    FIRST_OBJ   = 3'd2,
    NEXT_OBJ    = 3'd3,
    OBJ_DATA    = 3'd4,
    HALTED      = 3'd5,
    ENC_PENDING = 3'd6,
    ENC_PAYLOAD = 3'd7
  } parse_phase_e;

  localparam logic [7:0] KNOWN_IDS [0:40] = '{
    8'h01, 8'h2E, 8'h2F,
    8'h02, 8'h03, 8'h08, 8'h0C, 8'h12, 8'h13, 8'h14, 8'h3C, 8'h40, 8'h41,
    8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h51, 8'h52, 8'h56, 8'h57,
    8'h58, 8'h5E, 8'h5F,
    8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h49, 8'h4B,
    8'h3E, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h5B, 8'h5C
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int unsigned cycle_count = 0;

  // Payload length of an object ID; zero marks an ID the parser does not know
  function automatic logic [2:0] payload_len(logic [7:0] id);
    case (id)
      8'h01, 8'h2E, 8'h2F: return 3'd1;
      8'h02, 8'h03, 8'h08, 8'h0C, 8'h12, 8'h13, 8'h14, 8'h3C, 8'h40, 8'h41,
      8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h51, 8'h52, 8'h56, 8'h57,
      8'h58, 8'h5E, 8'h5F: return 3'd2;
      8'h04, 8'h05, 8'h0A, 8'h0B, 8'h42, 8'h49, 8'h4B: return 3'd3;
      8'h3E, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h5B, 8'h5C: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  // Number of decimal places in the reading of an object ID
  function automatic logic [1:0] decimals_of(logic [7:0] id);
    case (id)
      8'h02, 8'h03, 8'h04, 8'h05, 8'h08, 8'h0B, 8'h14, 8'h44, 8'h5C,
      8'h5E: return 2'd2;
      8'h0A, 8'h0C, 8'h42, 8'h43, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h51,
      8'h52: return 2'd3;
      8'h3F, 8'h45, 8'h46, 8'h47, 8'h4A: return 2'd1;
      default: return 2'd0;
    endcase
  endfunction

  class advert_scoreboard;
    parse_phase_e phase;
    logic [2:0]   mac_left;
    logic [7:0]   obj_id;
    logic [2:0]   data_left;
    logic [31:0]  accum;
    logic [1:0]   shift_pos;
    logic [2:0]   reason;
    out_word_t    expected_words[$];
    int           fail_count;
    int           checked;
    int           kind_seen[3];
    int           status_seen[5];

    function new();
      fail_count = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      phase     = WAIT_HDR;
      mac_left  = '0;
      obj_id    = '0;
      data_left = '0;
      accum     = '0;
      shift_pos = '0;
      reason    = ST_COMPLETE;
    endfunction

    function void enter_payload();
      phase = (reason == ST_ENCRYPTED) ? ENC_PENDING : FIRST_OBJ;
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= 10) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // Advance the parser copy by one accepted byte and queue the words it yields
    function void note_byte(in_word_t w);
      out_word_t  res[2];
      int         n;
      logic [7:0] b;
      logic [2:0] len;
      logic [2:0] status;
      n = 0;
      b = w.data_byte;
      case (phase)
        WAIT_HDR: begin
          res[n] = '0;
          res[n].item_kind      = KIND_HEADER;
          res[n].format_version = b[7:5];
          res[n].encrypted_flag = b[0];
          res[n].mac_present    = b[1];
          res[n].trigger_flag   = b[2];
          n++;
          reason = b[0] ? ST_ENCRYPTED : ST_COMPLETE;
          if (b[1]) begin
            phase    = SKIP_MAC;
            mac_left = MAC_BYTES;
          end else begin
            enter_payload();
          end
        end
        SKIP_MAC: begin
          mac_left = mac_left - 3'd1;
          if (mac_left == 3'd0) enter_payload();
        end
        FIRST_OBJ, NEXT_OBJ: begin
          len = payload_len(b);
          if (len == 3'd0) begin
            phase  = HALTED;
            reason = ST_UNKNOWN;
          end else begin
            obj_id    = b;
            data_left = len;
            accum     = '0;
            shift_pos = '0;
            phase     = OBJ_DATA;
          end
        end
        OBJ_DATA: begin
          accum     = accum | ({24'd0, b} << {shift_pos, 3'b000});
          shift_pos = shift_pos + 2'd1;
          data_left = data_left - 3'd1;
          if (data_left == 3'd0) begin
            res[n] = '0;
            res[n].item_kind   = KIND_MEASURE;
            res[n].object_code = obj_id;
            res[n].raw_reading = accum;
            res[n].scale_code  = decimals_of(obj_id);
            n++;
            phase = NEXT_OBJ;
          end
        end
        ENC_PENDING: phase = ENC_PAYLOAD;
        default: ;
      endcase
      if (w.frame_end) begin
        case (phase)
          NEXT_OBJ:    status = ST_COMPLETE;
          OBJ_DATA:    status = ST_TRUNC;
          HALTED:      status = ST_UNKNOWN;
          ENC_PAYLOAD: status = ST_ENCRYPTED;
          default:     status = ST_NOPAYLOAD;
        endcase
        res[n] = '0;
        res[n].item_kind  = KIND_END;
        res[n].end_status = status;
        n++;
        clear_frame();
      end
      if (n > 0) res[n-1].last_result = 1'b1;
      for (int i = 0; i < n; i++) expected_words.insert(expected_words.size(), res[i]);
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      string     bad;
      if (expected_words.size() == 0) begin
        report($sformatf("result word %h with none expected", got));
        return;
      end
      want = expected_words.pop_front();
      bad = "";
      if (got.item_kind      !== want.item_kind)      bad = {bad, " item_kind"};
      if (got.object_code    !== want.object_code)    bad = {bad, " object_code"};
      if (got.raw_reading    !== want.raw_reading)    bad = {bad, " raw_reading"};
      if (got.scale_code     !== want.scale_code)     bad = {bad, " scale_code"};
      if (got.format_version !== want.format_version) bad = {bad, " format_version"};
      if (got.encrypted_flag !== want.encrypted_flag) bad = {bad, " encrypted_flag"};
      if (got.mac_present    !== want.mac_present)    bad = {bad, " mac_present"};
      if (got.trigger_flag   !== want.trigger_flag)   bad = {bad, " trigger_flag"};
      if (got.end_status     !== want.end_status)     bad = {bad, " end_status"};
      if (got.last_result    !== want.last_result)    bad = {bad, " last_result"};
      if (bad != "")
        report($sformatf("word %0d differs in%s: expected %h, got %h",
                         checked, bad, want, got));
      checked++;
      if (want.item_kind <= KIND_END) kind_seen[want.item_kind]++;
      if (want.item_kind == KIND_END && want.end_status <= ST_ENCRYPTED)
        status_seen[want.end_status]++;
    endfunction

    function void check_drained();
      if (expected_words.size() != 0)
        report($sformatf("%0d result words never arrived", expected_words.size()));
    endfunction
  endclass

  advert_scoreboard sb;
  in_word_t         stream[$];
  logic [7:0]       frame_buf[$];
  int               frames_built = 0;

  sensor_advert_object_parser_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still expected", cycle_count,
               sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver stalls follow a 16-bit pattern, indexed by the cycle count, that is redrawn now and then
  logic [15:0] stall_pat = 16'hFFFF;
  int          pat_age = 0;
  always @(posedge clk) begin
    if (pat_age == 0) begin
      stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom()) | 16'h0001);
      pat_age   = $urandom_range(20, 150);
    end else begin
      pat_age--;
    end
    out_ready <= stall_pat[cycle_count[3:0]];
  end

  // Note accepted words on both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (out_valid && out_ready) sb.check_word(out_data);
    end
  end

  task automatic pb(logic [7:0] b);
    frame_buf.insert(frame_buf.size(), b);
  endtask

  // Move the frame being built into the stream, marking its last byte
  task automatic close_frame();
    in_word_t w;
    for (int i = 0; i < frame_buf.size(); i++) begin
      w.data_byte = frame_buf[i];
      w.frame_end = (i == frame_buf.size() - 1);
      stream.insert(stream.size(), w);
    end
    if (frame_buf.size() > 0) frames_built++;
    frame_buf.delete();
  endtask

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(0, 3);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_directed();
    // encrypted one-byte frame
    pb(8'h01); close_frame();
    // frame ending on the last MAC byte
    pb(8'hE6); pb(8'h00); pb(8'h11); pb(8'h22); pb(8'h33); pb(8'h44); pb(8'hFF);
    close_frame();
    // encrypted frame with payload
    pb(8'h05); pb(8'hAA); pb(8'h55); close_frame();
    // complete frame, widest object at its largest value
    pb(8'h40); pb(8'h3E); repeat (4) pb(8'hFF); close_frame();
    // unknown ID on the last byte
    pb(8'h40); pb(8'h00); close_frame();
    // unknown ID, later byte ignored
    pb(8'h40); pb(8'h99); pb(8'h01); close_frame();
    // ends on an ID byte, then inside the data
    pb(8'h40); pb(8'h02); close_frame();
    pb(8'h40); pb(8'h02); pb(8'h34); close_frame();
  endtask

  task automatic add_random_frame();
    int         roll;
    int         cut;
    logic [7:0] hdr;
    logic [7:0] id;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      repeat ($urandom_range(1, 10)) pb(8'($urandom_range(0, 255)));
    end else begin
      hdr    = 8'($urandom_range(0, 255));
      hdr[0] = ($urandom_range(0, 9) == 0);
      hdr[1] = ($urandom_range(0, 3) == 0);
      pb(hdr);
      if (hdr[1]) repeat (6) pb(8'($urandom_range(0, 255)));
      if (hdr[0]) begin
        repeat ($urandom_range(0, 6)) pb(8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 19) == 0) id = 8'($urandom_range(0, 255));
          else id = KNOWN_IDS[$urandom_range(0, 40)];
          pb(id);
          repeat (payload_len(id)) pb(pick_value());
        end
      end
      // cut some frames short, anywhere after the header
      if (roll >= 85 && frame_buf.size() > 1) begin
        cut = $urandom_range(1, frame_buf.size() - 1);
        while (frame_buf.size() > cut) void'(frame_buf.pop_back());
      end
    end
    close_frame();
  endtask

  // Offer words in bursts; hold valid and payload until each word is taken
  task automatic send_words();
    int pos;
    int burst_left;
    int gap_left;
    int idle_pct;
    int era;
    bit done;
    pos = 0; burst_left = 0; gap_left = 0; idle_pct = 30; era = -1; done = 0;
    while (!done) begin
      @(posedge clk);
      if (in_valid && in_ready) begin
        pos++;
        if (burst_left > 0) burst_left--;
      end
      if (!(in_valid && !in_ready)) begin
        if (pos >= stream.size()) begin
          in_valid <= 1'b0;
          done = 1;
        end else begin
          if (pos / 256 != era) begin
            era = pos / 256;
            case ($urandom_range(0, 3))
              0: idle_pct = 0;
              1: idle_pct = 20;
              2: idle_pct = 50;
              default: idle_pct = 80;
            endcase
          end
          if (burst_left == 0 && gap_left == 0) begin
            gap_left   = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 8) : 0;
            burst_left = $urandom_range(1, 24);
          end
          if (gap_left > 0) begin
            in_valid <= 1'b0;
            gap_left--;
          end else begin
            in_valid <= 1'b1;
            in_data  <= stream[pos];
          end
        end
      end
    end
  endtask

  initial begin
    int directed_bytes;
    sb = new();
    add_directed();
    directed_bytes = stream.size();
    while (stream.size() < directed_bytes + RANDOM_BYTES) add_random_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    send_words();
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.check_drained();
    $display("Sent %0d bytes in %0d frames; checked %0d headers, %0d measurements, %0d ends",
             stream.size(), frames_built, sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2]);
    $display("Frame ends complete/no-payload/unknown/truncated/encrypted: %0d/%0d/%0d/%0d/%0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3],
             sb.status_seen[4]);
    if (sb.fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", sb.fail_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sao_pkg.sv
rtl/sensor_advert_object_parser_unit.sv
tb/tb_top.sv
